// ----- hdl/prdt_pkg.sv -----
// shared types and constants for the prescaled reload down timer
`default_nettype none

package prdt_pkg;

    // base divider and counter width
    localparam int FIXED_DIVIDER = 32;
    localparam int COUNT_WIDTH   = 16;

    // largest prescaler shift, from the three-bit prescaler field
    localparam int PRESC_MAX = 7;
    // phase counts up to one below the largest divider
    localparam int PHASE_W   = $clog2(FIXED_DIVIDER << PRESC_MAX);
    localparam int DIV_W     = PHASE_W + 1;

    // field widths
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 16;
    localparam int CTL_W   = 8;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_CTL   = 8'd0;
    localparam logic [ADDR_W-1:0] ADDR_LOAD  = 8'd2;
    localparam logic [ADDR_W-1:0] ADDR_COUNT = 8'd4;

    // control bit positions
    localparam int CTL_START  = 0;
    localparam int CTL_RELOAD = 1;
    localparam int CTL_PRESC_LO = 2;
    localparam int CTL_PRESC_HI = 4;
    localparam int CTL_CLKEN  = 5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/prdt_engine.sv -----
// timer state registers and the per-item update and read logic
`default_nettype none

module prdt_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire prdt_pkg::t_item i_item,
    output prdt_pkg::t_result    o_result
);
    import prdt_pkg::*;

    logic [CTL_W-1:0]       r_ctl, n_ctl;
    logic [COUNT_WIDTH-1:0] r_load, n_load;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_running, n_running;
    logic [PHASE_W-1:0]     r_phase, n_phase;

    logic [2:0]             presc_cur;
    logic [2:0]             presc_new;
    logic [DIV_W-1:0]       divider;
    logic [DIV_W-1:0]       phase_inc;
    logic [CTL_W-1:0]       ctl_wr;
    logic                   run_req;

    // current divider and incremented phase
    always_comb begin
        presc_cur = r_ctl[CTL_PRESC_HI:CTL_PRESC_LO];
        divider   = DIV_W'(FIXED_DIVIDER) << presc_cur;
        phase_inc = DIV_W'(r_phase) + DIV_W'(1);
        ctl_wr    = i_item.wdata[CTL_W-1:0];
        presc_new = ctl_wr[CTL_PRESC_HI:CTL_PRESC_LO];
        run_req   = ctl_wr[CTL_START] & ctl_wr[CTL_CLKEN];
    end

    // next state and result for one item
    always_comb begin
        n_ctl     = r_ctl;
        n_load    = r_load;
        n_count   = r_count;
        n_running = r_running;
        n_phase   = r_phase;
        o_result  = '0;
        unique case (i_item.mode)
            MODE_TICK: begin
                if (r_running) begin
                    if (phase_inc >= divider) begin
                        n_phase = '0;
                        if (r_count != '0) begin
                            n_count = r_count - COUNT_WIDTH'(1);
                        end else begin
                            o_result.irq = 1'b1;
                            if (r_ctl[CTL_RELOAD]) begin
                                n_count = r_load;
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                    end else begin
                        n_phase = phase_inc[PHASE_W-1:0];
                    end
                end
            end
            MODE_READ: begin
                if (i_item.addr == ADDR_CTL) begin
                    o_result.rdata = DATA_W'(r_ctl);
                end else if (i_item.addr == ADDR_LOAD) begin
                    o_result.rdata = DATA_W'(r_load);
                end else if (i_item.addr == ADDR_COUNT) begin
                    o_result.rdata = DATA_W'(r_count);
                end
            end
            MODE_WRITE: begin
                if (i_item.addr == ADDR_CTL) begin
                    n_ctl = ctl_wr;
                    if (run_req) begin
                        if (!r_running) begin
                            if (r_load != '0) begin
                                n_count   = r_load;
                                n_running = 1'b1;
                                n_phase   = '0;
                            end
                        end else if (presc_new != presc_cur) begin
                            n_phase = '0;
                        end
                    end else begin
                        n_running = 1'b0;
                    end
                end else if (i_item.addr == ADDR_LOAD) begin
                    n_load = COUNT_WIDTH'(i_item.wdata);
                end
            end
            default: begin
            end
        endcase
    end

    // state update on each transfer through the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_load    <= '0;
            r_count   <= '0;
            r_running <= 1'b0;
            r_phase   <= '0;
        end else if (i_fire) begin
            r_ctl     <= n_ctl;
            r_load    <= n_load;
            r_count   <= n_count;
            r_running <= n_running;
            r_phase   <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/prescaled_reload_down_timer_core.sv -----
// Prescaled 16-bit down timer with auto-reload. Every transfer on the input
// channel is a base-clock tick, register read, register write or a spare-mode
// no-op, and yields exactly one result (read data and irq pulse). One item is
// taken per clock unless the input stalls. Each item passes the input register
// and the single update stage, and its result is held in the result register
// until taken. The input side stalls only while both registers are full and
// the output is stalled.
`default_nettype none

module prescaled_reload_down_timer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [prdt_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [prdt_pkg::ADDR_W-1:0]   i_addr,
    input  wire logic [prdt_pkg::DATA_W-1:0]   i_wdata,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [prdt_pkg::DATA_W-1:0]        o_rdata,
    output logic                               o_irq
);
    import prdt_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result result;
    logic    advance;

    // item moves from input register to result register when the latter is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.mode  <= i_mode;
            r_item.addr  <= i_addr;
            r_item.wdata <= i_wdata;
        end
    end

    // timer state and update logic
    prdt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_result.rdata;
    assign o_irq       = r_result.irq;

endmodule

`default_nettype wire

// ----- hdl/prdt_checker.sv -----
// port-level checks for the timer core, bound to the top level
`default_nettype none

module prdt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [prdt_pkg::DATA_W-1:0] o_rdata,
    input wire logic                        o_irq
);
    import prdt_pkg::*;

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rdata) && $stable(o_irq))
        else $error("stalled result changed");

    // input backs up only when the output side is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // irq comes only from ticks, which return no read data
    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq |-> o_rdata == '0)
        else $error("irq together with read data");

endmodule

bind prescaled_reload_down_timer_core prdt_checker u_prdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rdata     (o_rdata),
    .o_irq       (o_irq)
);

`default_nettype wire

// ----- bench/prescaled_reload_down_timer_core_tb.sv -----
// self-checking testbench for the prescaled reload down timer core
module prescaled_reload_down_timer_core_tb;
    import prdt_pkg::*;

    // run limits and pacing
    localparam int LIMIT_CYCLES = 500000;
    localparam int BLOCK_ITEMS  = 460;
    localparam int BLOCK_IRQS   = 3;
    localparam int BLOCK_CAP    = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 10;

    // mode value the block leaves unused, and an offset with no register
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 8'hFF;

    // control words
    localparam logic [DATA_W-1:0] W_START  = 16'd1 << CTL_START;
    localparam logic [DATA_W-1:0] W_RELOAD = 16'd1 << CTL_RELOAD;
    localparam logic [DATA_W-1:0] W_CLKEN  = 16'd1 << CTL_CLKEN;
    localparam logic [DATA_W-1:0] W_RUN    = W_START | W_CLKEN;
    localparam logic [DATA_W-1:0] W_ALL    = 16'hFFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic              typed;
        logic [DATA_W-1:0] rdata;
        logic              irq;
    } t_dir_row;

    // directed stimulus: register extremes, ignored accesses, start, reload, stop
    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset values and unmapped accesses
        '{MODE_READ,  ADDR_CTL,      16'h0000, 1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_LOAD,     16'h0000, 1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_UNMAPPED, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{MODE_SPARE, ADDR_UNMAPPED, W_ALL,    1'b1, 16'h0000, 1'b0},
        // start with zero load stays stopped
        '{MODE_WRITE, ADDR_CTL,      W_RUN,    1'b1, 16'h0000, 1'b0},
        '{MODE_TICK,  ADDR_CTL,      16'h0000, 1'b1, 16'h0000, 1'b0},
        '{MODE_WRITE, ADDR_LOAD,     W_ALL,    1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_LOAD,     16'h0000, 1'b1, 16'hFFFF, 1'b0},
        // count is read-only, unmapped write dropped
        '{MODE_WRITE, ADDR_COUNT,    16'h1234, 1'b1, 16'h0000, 1'b0},
        '{MODE_WRITE, ADDR_UNMAPPED, W_ALL,    1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b1, 16'h0000, 1'b0},
        // all control bits set, upper byte dropped, count takes the full load
        '{MODE_WRITE, ADDR_CTL,      W_ALL,    1'b1, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_CTL,      16'h0000, 1'b1, 16'h00FF, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b1, 16'hFFFF, 1'b0},
        '{MODE_TICK,  ADDR_LOAD,     W_ALL,    1'b0, 16'h0000, 1'b0},
        // load change while running waits for the next reload
        '{MODE_WRITE, ADDR_LOAD,     16'h0001, 1'b0, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b0, 16'h0000, 1'b0},
        // prescaler change while running clears the phase
        '{MODE_WRITE, ADDR_CTL,      W_RUN | W_RELOAD, 1'b0, 16'h0000, 1'b0},
        '{MODE_TICK,  ADDR_CTL,      16'h0000, 1'b0, 16'h0000, 1'b0},
        // stop freezes the count, restart takes the new load
        '{MODE_WRITE, ADDR_CTL,      W_CLKEN,  1'b0, 16'h0000, 1'b0},
        '{MODE_TICK,  ADDR_CTL,      16'h0000, 1'b0, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b0, 16'h0000, 1'b0},
        '{MODE_WRITE, ADDR_CTL,      W_RUN,    1'b0, 16'h0000, 1'b0},
        '{MODE_READ,  ADDR_COUNT,    16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [MODE_W-1:0] i_mode;
    logic [ADDR_W-1:0] i_addr;
    logic [DATA_W-1:0] i_wdata;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DATA_W-1:0] o_rdata;
    logic              o_irq;

    prescaled_reload_down_timer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_addr      (i_addr),
        .i_wdata     (i_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rdata     (o_rdata),
        .o_irq       (o_irq)
    );

    // timer state as predicted
    logic [CTL_W-1:0]       tm_ctl;
    logic [COUNT_WIDTH-1:0] tm_load;
    logic [COUNT_WIDTH-1:0] tm_count;
    logic                   tm_running;
    logic [PHASE_W-1:0]     tm_phase;

    t_result pending_results[$];
    int      mismatch_count;
    int      result_idx;
    int      item_total;
    int      irq_total;
    int      cycle_count;
    int      snd_idle;
    int      rcv_idle;
    bit      hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // one mismatch line and count
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch on result %0d: %s got %h want %h", result_idx, what, got, want);
        mismatch_count++;
    endtask

    // next timer result for one transfer, updating the predicted state
    function automatic t_result predict_timer_result(input logic [MODE_W-1:0] mode,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [DATA_W-1:0] wdata);
        t_result    res;
        logic [2:0] old_presc;
        res = '0;
        old_presc = tm_ctl[CTL_PRESC_HI:CTL_PRESC_LO];
        case (mode)
            MODE_TICK: begin
                if (tm_running) begin
                    if (int'(tm_phase) + 1 >= (FIXED_DIVIDER << old_presc)) begin
                        tm_phase = '0;
                        if (tm_count != '0) begin
                            tm_count = tm_count - 1'b1;
                        end else begin
                            // wrap past zero: reload or halt at zero
                            res.irq = 1'b1;
                            if (tm_ctl[CTL_RELOAD]) tm_count = tm_load;
                            else tm_running = 1'b0;
                        end
                    end else begin
                        tm_phase = tm_phase + 1'b1;
                    end
                end
            end
            MODE_READ: begin
                if (addr == ADDR_CTL) res.rdata = DATA_W'(tm_ctl);
                else if (addr == ADDR_LOAD) res.rdata = tm_load;
                else if (addr == ADDR_COUNT) res.rdata = tm_count;
            end
            MODE_WRITE: begin
                if (addr == ADDR_CTL) begin
                    tm_ctl = wdata[CTL_W-1:0];
                    if (tm_ctl[CTL_START] && tm_ctl[CTL_CLKEN]) begin
                        if (!tm_running) begin
                            // start needs a nonzero load
                            if (tm_load != '0) begin
                                tm_count   = tm_load;
                                tm_running = 1'b1;
                                tm_phase   = '0;
                            end
                        end else if (old_presc != tm_ctl[CTL_PRESC_HI:CTL_PRESC_LO]) begin
                            tm_phase = '0;
                        end
                    end else begin
                        tm_running = 1'b0;
                    end
                end else if (addr == ADDR_LOAD) begin
                    tm_load = wdata[COUNT_WIDTH-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // offer one item, wait for its transfer, then queue the expected result
    task automatic push_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, input logic typed = 1'b0,
                             input logic [DATA_W-1:0] typed_rdata = '0,
                             input logic typed_irq = 1'b0);
        t_result want;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_addr     <= addr;
        i_wdata    <= wdata;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        want = predict_timer_result(mode, addr, wdata);
        if (typed) begin
            want.rdata = typed_rdata;
            want.irq   = typed_irq;
        end
        pending_results.push_back(want);
        irq_total += want.irq;
        if (mode != MODE_SPARE) item_total++;
    endtask

    // mostly short loads, sometimes zero or the full range
    function automatic logic [DATA_W-1:0] pick_load();
        int r;
        r = $urandom_range(99);
        if (r < 65) return DATA_W'($urandom_range(1, 3));
        if (r < 92) return DATA_W'($urandom_range(0, 15));
        return DATA_W'($urandom);
    endfunction

    // mostly the fastest prescaler so that wraps come often
    function automatic logic [2:0] pick_presc();
        if ($urandom_range(99) < 85) return 3'd0;
        return 3'($urandom_range(0, PRESC_MAX));
    endfunction

    // random part: timer runs with random content plus noise, then drain
    task automatic random_block(input int snd_pct, input int rcv_pct, input bit with_hold);
        int                start_items;
        int                start_irqs;
        int                pick;
        logic [DATA_W-1:0] w;
        snd_idle    = snd_pct;
        rcv_idle    = rcv_pct;
        hold_req    = with_hold;
        start_items = item_total;
        start_irqs  = irq_total;
        while (((item_total - start_items) < BLOCK_ITEMS
                || (irq_total - start_irqs) < BLOCK_IRQS)
               && (item_total - start_items) < BLOCK_CAP) begin
            if ($urandom_range(99) < 80) begin
                // optional stop so that the next control write restarts
                if ($urandom_range(1) == 1) begin
                    w = DATA_W'($urandom);
                    if ($urandom_range(1) == 1) w[CTL_START] = 1'b0;
                    else w[CTL_CLKEN] = 1'b0;
                    push_item(MODE_WRITE, ADDR_CTL, w);
                end
                push_item(MODE_WRITE, ADDR_LOAD, pick_load());
                w = DATA_W'($urandom);
                w[CTL_START]  = 1'b1;
                w[CTL_CLKEN]  = 1'b1;
                w[CTL_RELOAD] = ($urandom_range(9) < 7);
                w[CTL_PRESC_HI:CTL_PRESC_LO] = pick_presc();
                push_item(MODE_WRITE, ADDR_CTL, w);
                // stretch of ticks with bus accesses mixed in
                repeat ($urandom_range(40, 260)) begin
                    pick = $urandom_range(99);
                    if (pick < 90) begin
                        push_item(MODE_TICK, ADDR_W'($urandom), DATA_W'($urandom));
                    end else if (pick < 93) begin
                        case ($urandom_range(2))
                            0: push_item(MODE_READ, ADDR_CTL, DATA_W'($urandom));
                            1: push_item(MODE_READ, ADDR_LOAD, DATA_W'($urandom));
                            default: push_item(MODE_READ, ADDR_COUNT, DATA_W'($urandom));
                        endcase
                    end else if (pick < 95) begin
                        push_item(MODE_WRITE, ADDR_LOAD, pick_load());
                    end else if (pick < 97) begin
                        w[CTL_PRESC_HI:CTL_PRESC_LO] = pick_presc();
                        push_item(MODE_WRITE, ADDR_CTL, w);
                    end else if (pick < 98) begin
                        push_item(MODE_WRITE, ADDR_CTL, w & ~W_CLKEN);
                    end else begin
                        push_item(MODE_WRITE, ADDR_COUNT, DATA_W'($urandom));
                    end
                end
            end else begin
                // noise over every mode, offset and data bit
                repeat ($urandom_range(1, 8))
                    push_item(MODE_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
            end
        end
        // pause until every expected result has come
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender: reset, directed table, random blocks, end of run
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = MODE_TICK;
        i_addr     = ADDR_CTL;
        i_wdata    = '0;
        tm_ctl     = '0;
        tm_load    = '0;
        tm_count   = '0;
        tm_running = 1'b0;
        tm_phase   = '0;
        snd_idle   = 30;
        rcv_idle   = 57;
        hold_req   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TABLE[r])
            push_item(DIR_TABLE[r].mode, DIR_TABLE[r].addr, DIR_TABLE[r].wdata,
                      DIR_TABLE[r].typed, DIR_TABLE[r].rdata, DIR_TABLE[r].irq);

        random_block(30, 57, 1'b1);
        random_block(57, 30, 1'b1);
        random_block(0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** prescaled_reload_down_timer_core: PASSED **");
        else
            $display("** prescaled_reload_down_timer_core: FAILED **");
        $finish;
    end

    // receiver: random stall, or a long hold-off when asked
    initial begin
        int  hold_left;
        bit  stall_next;
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else begin
                stall_next = ($urandom_range(99) < rcv_idle);
            end
            @(negedge i_clk);
            i_out_stall <= stall_next;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, rdata", o_rdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_rdata !== want.rdata) report_mismatch("rdata", o_rdata, want.rdata);
                if (o_irq !== want.irq)
                    report_mismatch("irq", DATA_W'(o_irq), DATA_W'(want.irq));
            end
            result_idx++;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** prescaled_reload_down_timer_core: FAILED **");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
hdl/prdt_pkg.sv
hdl/prdt_engine.sv
hdl/prescaled_reload_down_timer_core.sv
hdl/prdt_checker.sv
bench/prescaled_reload_down_timer_core_tb.sv
